FILE: hw/rtl/star_wildcard_name_matcher_core_macros.svh
// Assertion macros shared by the verification files of the wildcard name matcher.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef STAR_WILDCARD_NAME_MATCHER_CORE_MACROS_SVH
`define STAR_WILDCARD_NAME_MATCHER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWNM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWNM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/swnm_pkg.sv
// Shared types and constants of the wildcard name matcher.
// Used by the interfaces, the cell, the top level and the checker.
package swnm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam logic [7:0] STAR_BYTE = 8'h2A;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_NAME   = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    // Broadcast to every cell in the chain.
    typedef struct packed {
        logic       en;
        kind_t      kind;
        logic [7:0] char_value;
    } cmd_t;

    // Passed from one cell to its right-hand neighbour.
    typedef struct packed {
        logic valid;    // this position holds a pattern byte
        logic shift;    // position advances on a literal match
        logic closure;  // active star enables the following position
    } link_t;

endpackage

FILE: hw/rtl/swnm_if.sv
// Valid/ready channel interfaces of the wildcard name matcher.
// Depends on swnm_pkg for the kind type.
interface swnm_in_if import swnm_pkg::*;;
    logic       valid;
    logic       ready;
    kind_t      kind;
    logic [7:0] char_value;

    modport source (output valid, output kind, output char_value, input ready);
    modport sink (input valid, input kind, input char_value, output ready);
endinterface

interface swnm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink (input valid, input matched, input pattern_overflow, output ready);
endinterface

FILE: hw/rtl/swnm_cell.sv
// One pattern position of the matcher: its byte, its occupancy and its active bit.
// Depends on swnm_pkg; instantiated in a row by the top level.
module swnm_cell import swnm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    input  logic  a_force,
    input  link_t left,
    output link_t right,
    output logic  tail
);

    logic       valid_reg;
    logic       valid_next;
    logic       act_reg;
    logic       act_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       act;
    logic       write;
    logic       is_name;
    logic       star_cur;
    logic       pre;

    assign act      = act_reg | a_force;
    assign is_name  = (cmd.kind == KIND_NAME);
    assign write    = (cmd.kind == KIND_APPEND) && left.valid && !valid_reg;
    assign star_cur = (byte_reg == STAR_BYTE);

    always_comb
    begin
        unique case (cmd.kind)
            KIND_CLEAR:  valid_next = 1'b0;
            KIND_APPEND: valid_next = valid_reg | left.valid;
            default:     valid_next = valid_reg;
        endcase
    end

    assign byte_next = write ? cmd.char_value : byte_reg;

    // On a name byte an active star stays active; otherwise the position set is
    // rebuilt from the seed that enters at the left end of the row.
    assign pre      = left.shift | (is_name & act & valid_reg & star_cur);
    assign act_next = pre | left.closure;

    assign right.valid   = valid_reg;
    assign right.shift   = is_name & act & valid_reg & !star_cur
                           & (byte_reg == cmd.char_value);
    assign right.closure = act_next & valid_next & (byte_next == STAR_BYTE);

    // Positions at or beyond the pattern length; only the one at the length can be set.
    assign tail = act & !valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            act_reg   <= 1'b0;
        end
        else if (cmd.en)
        begin
            valid_reg <= valid_next;
            act_reg   <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.en && write)
        begin
            byte_reg <= byte_next;
        end
    end

endmodule

FILE: hw/rtl/star_wildcard_name_matcher_core.sv
// Top level of the star-only wildcard name matcher.
// Depends on swnm_pkg, the channel interfaces in swnm_if and swnm_cell.
//
// Usage: transactions arrive on the items channel (kind, char_value). Kind clear
// empties the pattern, append adds one pattern byte (a star matches any run of
// name bytes), name feeds one name byte, end finishes the name. Only an end
// transaction gives a result on the results channel: matched and
// pattern_overflow. Patterns longer than MAX_PATTERN bytes are truncated and
// the overflow flag stays set until the next clear.
// Throughput: one item per clock while the results channel does not stall. Each
// pattern position is a cell in a row; the position set of a whole name byte
// is updated at once through the row of cells, including the ripple over runs
// of stars. The result is registered and appears in the cycle after the end
// transaction is taken. The result register is a single stage; while it holds
// a result that the receiver stalls, items is not ready, and it becomes ready
// in the same cycle as the receiver takes the result.
// Reset: the pattern is empty, the overflow flag is clear and the matcher is
// armed, so an end transaction right after reset reports a match.
module star_wildcard_name_matcher_core import swnm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    swnm_in_if.sink    items,
    swnm_out_if.source results
);

    cmd_t                   cmd;
    link_t                  links [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] tails;
    logic                   accept;
    logic                   boot_reg;
    logic                   last_reg;
    logic                   last_next;
    logic                   overflow_reg;
    logic                   overflow_next;
    logic                   out_valid_reg;
    logic                   matched_reg;
    logic                   out_overflow_reg;
    logic                   verdict;

    assign items.ready = !out_valid_reg || results.ready;
    assign accept      = items.valid && items.ready;

    assign cmd.en         = accept;
    assign cmd.kind       = items.kind;
    assign cmd.char_value = items.char_value;

    // The left end of the row always counts as occupied; every kind but a name
    // byte seeds position zero, which rearms the position set.
    assign links[0].valid   = 1'b1;
    assign links[0].shift   = (items.kind != KIND_NAME);
    assign links[0].closure = 1'b0;

    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        logic force_bit;
        if (i == 0)
        begin : g_head
            assign force_bit = boot_reg;
        end
        else
        begin : g_body
            assign force_bit = 1'b0;
        end

        swnm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .a_force (force_bit),
            .left    (links[i]),
            .right   (links[i+1]),
            .tail    (tails[i])
        );
    end

    // The position after a full pattern.
    assign last_next = links[MAX_PATTERN].shift | links[MAX_PATTERN].closure;
    assign verdict   = (|tails) | last_reg;

    always_comb
    begin
        unique case (items.kind)
            KIND_CLEAR:  overflow_next = 1'b0;
            KIND_APPEND: overflow_next = overflow_reg | links[MAX_PATTERN].valid;
            default:     overflow_next = overflow_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_reg     <= 1'b1;
            last_reg     <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else if (accept)
        begin
            boot_reg     <= 1'b0;
            last_reg     <= last_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && (items.kind == KIND_END))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (items.kind == KIND_END))
        begin
            matched_reg      <= verdict;
            out_overflow_reg <= overflow_reg;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.matched          = matched_reg;
    assign results.pattern_overflow = out_overflow_reg;

endmodule

FILE: hw/rtl/swnm_checker.sv
// Port-level assertions for the wildcard name matcher, bound to its top level.
// Depends on swnm_pkg and the macros header.
`include "star_wildcard_name_matcher_core_macros.svh"

module swnm_checker import swnm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] in_kind,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_matched,
    input logic       out_overflow
);

    logic in_acc;
    logic end_acc;
    logic clear_acc;

    assign in_acc    = in_valid && in_ready;
    assign end_acc   = in_acc && (in_kind == KIND_END);
    assign clear_acc = in_acc && (in_kind == KIND_CLEAR);

    `SWNM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `SWNM_ASSERT_NEXT(a_end_gives_result, end_acc, out_valid, "end transaction gave no result")
    `SWNM_ASSERT_SAME(a_no_invented, $rose(out_valid), $past(end_acc), "result without end transaction")
    `SWNM_ASSERT_NEXT(a_empty_match, clear_acc ##1 end_acc, out_matched && !out_overflow, "empty name did not match empty pattern")

endmodule

bind star_wildcard_name_matcher_core swnm_checker u_swnm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (items.valid),
    .in_ready     (items.ready),
    .in_kind      (items.kind),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_matched  (results.matched),
    .out_overflow (results.pattern_overflow)
);

FILE: tb/sv/tb.sv
// Self-checking testbench of the star-only wildcard name matcher.
// Depends on swnm_pkg, the channel interfaces in swnm_if and star_wildcard_name_matcher_core.
`timescale 1ns / 1ps

import swnm_pkg::*;

typedef struct packed {
    logic matched;
    logic overflow;
} verdict_t;

// Tracks the pattern store and the set of live pattern positions, and keeps
// the verdicts that the end-of-name transactions are due to produce.
class match_predictor;
    logic [7:0]         pat [MAX_PATTERN];
    int unsigned        pat_len;
    logic [MAX_PATTERN:0] live;
    logic               overflow;
    verdict_t           expected_verdicts [$];
    int unsigned        checked;
    int unsigned        mismatches;

    function new();
        pat_len = 0;
        overflow = 1'b0;
        checked = 0;
        mismatches = 0;
        rearm();
    endfunction

    // A live star also makes the following position live, since it may match
    // an empty run. Walking upwards covers runs of stars.
    function void close_stars();
        for (int i = 0; i < pat_len; i++)
            if (live[i] && pat[i] == STAR_BYTE)
                live[i + 1] = 1'b1;
    endfunction

    function void rearm();
        live = '0;
        live[0] = 1'b1;
        close_stars();
    endfunction

    function void step_name(logic [7:0] c);
        logic [MAX_PATTERN:0] nxt;
        nxt = '0;
        for (int i = 0; i < pat_len; i++)
        begin
            if (live[i])
            begin
                if (pat[i] == STAR_BYTE)
                    nxt[i] = 1'b1;
                else if (pat[i] == c)
                    nxt[i + 1] = 1'b1;
            end
        end
        live = nxt;
        close_stars();
    endfunction

    function void take_item(kind_t k, logic [7:0] c);
        verdict_t v;
        case (k)
            KIND_CLEAR:
            begin
                pat_len = 0;
                overflow = 1'b0;
                rearm();
            end
            KIND_APPEND:
            begin
                if (pat_len < MAX_PATTERN)
                begin
                    pat[pat_len] = c;
                    pat_len++;
                end
                else
                begin
                    overflow = 1'b1;
                end
                rearm();
            end
            KIND_NAME:
                step_name(c);
            default:
            begin
                v.matched = live[pat_len];
                v.overflow = overflow;
                expected_verdicts.push_back(v);
                rearm();
            end
        endcase
    endfunction

    function void flag(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR: %s", msg);
    endfunction

    function void check_result(logic m, logic o);
        verdict_t v;
        checked++;
        if (expected_verdicts.size() == 0)
        begin
            flag($sformatf("unexpected result matched=%0b pattern_overflow=%0b", m, o));
            return;
        end
        v = expected_verdicts.pop_front();
        if (m !== v.matched)
            flag($sformatf("result %0d: matched expected %0b, actual %0b",
                           checked, v.matched, m));
        if (o !== v.overflow)
            flag($sformatf("result %0d: pattern_overflow expected %0b, actual %0b",
                           checked, v.overflow, o));
    endfunction
endclass

module tb;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int LONG_HOLD = 400;
    localparam int RANDOM_ITEMS = 1800;

    logic clk;
    logic rst_n;

    swnm_in_if  items_if ();
    swnm_out_if results_if ();

    star_wildcard_name_matcher_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if)
    );

    match_predictor predictor;
    logic [7:0]     cur_pat [$];
    int unsigned    items_sent;
    int unsigned    cycle_count;
    bit             quiet;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Mostly back to back, sometimes a short gap and now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 8'h61;
        if (r < 65)
            return 8'h62;
        if (r < 80)
            return STAR_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic push_item(kind_t k, logic [7:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            items_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        items_if.valid = 1'b1;
        items_if.kind = k;
        items_if.char_value = c;
        do @(posedge clk); while (!items_if.ready);
        predictor.take_item(k, c);
        items_sent++;
        if (k == KIND_CLEAR)
            cur_pat.delete();
        else if (k == KIND_APPEND)
            cur_pat.push_back(c);
        @(negedge clk);
    endtask

    // Builds a name that the stored part of the current pattern accepts.
    task automatic push_matching_name();
        int n;
        n = (cur_pat.size() < MAX_PATTERN) ? cur_pat.size() : MAX_PATTERN;
        for (int i = 0; i < n; i++)
        begin
            if (cur_pat[i] == STAR_BYTE)
                repeat ($urandom_range(0, 3)) push_item(KIND_NAME, pick_byte());
            else
                push_item(KIND_NAME, cur_pat[i]);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off once results are flowing.
    initial
    begin
        int hold_left;
        bit long_done;
        hold_left = 0;
        long_done = 1'b0;
        results_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_done && predictor.checked >= 40)
            begin
                hold_left = LONG_HOLD;
                long_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                results_if.ready = 1'b0;
                hold_left--;
            end
            else
            begin
                results_if.ready = 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0)
                    hold_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
            predictor.check_result(results_if.matched, results_if.pattern_overflow);
    end

    initial
    begin
        int r;
        int len;
        predictor = new();
        items_sent = 0;
        cycle_count = 0;
        quiet = 1'b0;
        items_if.valid = 1'b0;
        items_if.kind = KIND_CLEAR;
        items_if.char_value = 8'h00;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty pattern against the empty name and a one-byte name.
        push_item(KIND_END, 8'h00);
        push_item(KIND_NAME, 8'h00);
        push_item(KIND_END, 8'h00);
        // A lone star matches anything, the empty name included.
        push_item(KIND_CLEAR, 8'h00);
        push_item(KIND_APPEND, STAR_BYTE);
        push_item(KIND_END, 8'h00);
        push_item(KIND_NAME, 8'hFF);
        push_item(KIND_NAME, 8'h00);
        push_item(KIND_END, 8'hFF);
        // Zero bytes as literals and a run of stars matching a star in the name.
        push_item(KIND_CLEAR, 8'hFF);
        push_item(KIND_APPEND, 8'h00);
        push_item(KIND_APPEND, STAR_BYTE);
        push_item(KIND_APPEND, STAR_BYTE);
        push_item(KIND_APPEND, 8'hFF);
        push_item(KIND_NAME, 8'h00);
        push_item(KIND_NAME, STAR_BYTE);
        push_item(KIND_NAME, 8'hFF);
        push_item(KIND_END, 8'h00);
        // An append part-way through a name restarts the name.
        push_item(KIND_NAME, 8'h00);
        push_item(KIND_APPEND, 8'h00);
        push_item(KIND_NAME, 8'h00);
        push_item(KIND_NAME, 8'hFF);
        push_item(KIND_NAME, 8'h00);
        push_item(KIND_END, 8'h00);
        push_item(KIND_NAME, 8'hFF);
        push_item(KIND_END, 8'hFF);

        while (items_sent < RANDOM_ITEMS + 25)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                repeat ($urandom_range(1, 6))
                    push_item(kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
            else if (r < 15)
            begin
                repeat ($urandom_range(0, 4)) push_item(KIND_NAME, pick_byte());
                push_item(KIND_APPEND, pick_byte());
                repeat ($urandom_range(0, 4)) push_item(KIND_NAME, pick_byte());
                push_item(KIND_END, 8'($urandom_range(0, 255)));
            end
            else
            begin
                if ($urandom_range(0, 9) != 0)
                    push_item(KIND_CLEAR, 8'($urandom_range(0, 255)));
                r = $urandom_range(0, 99);
                if (r < 85)
                    len = $urandom_range(0, 8);
                else if (r < 95)
                    len = $urandom_range(9, 31);
                else
                    len = $urandom_range(32, 40);
                repeat (len) push_item(KIND_APPEND, pick_byte());
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 1) == 0)
                        push_matching_name();
                    else
                        repeat ($urandom_range(0, 8)) push_item(KIND_NAME, pick_byte());
                    push_item(KIND_END, 8'($urandom_range(0, 255)));
                end
            end
        end
        items_if.valid = 1'b0;
        quiet = 1'b0;

        while (predictor.expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (predictor.expected_verdicts.size() != 0)
            predictor.flag("expected results left over at the end");
        if (predictor.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
